// ===== rtl/kvs_pkg.sv =====
// ----------------------------------------------------------------------------
// kvs_pkg: shared constants and types for the keyframe vector sampler
// Table depth, widths, modes, register address and divider command and status structs.
// ----------------------------------------------------------------------------
package kvs_pkg;
	localparam int MAX_KEYS = 16;
	localparam int IDX_W    = $clog2(MAX_KEYS);
	localparam int CNT_W    = $clog2(MAX_KEYS + 1);
	localparam int DATA_W   = 32;
	localparam int WGT_W    = 17;
	localparam int DIV_STEPS = 16;

	localparam logic [0:0] MODE_LOAD   = 1'b0;
	localparam logic [0:0] MODE_SAMPLE = 1'b1;

	localparam logic [0:0] REG_KEY_COUNT = 1'b0;

	typedef struct packed {
		logic start;
		logic [DATA_W-1:0] num;
		logic [DATA_W-1:0] den;
	} div_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [WGT_W-1:0] quo;
	} div_sts_t;
endpackage

// ===== rtl/kvs_div.sv =====
// ----------------------------------------------------------------------------
// kvs_div: serial restoring divider
// Computes (num << 16) / den, num < = den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module kvs_div (
	input  logic clk,
	input  logic arst_n,
	input  kvs_pkg::div_cmd_t cmd,
	output kvs_pkg::div_sts_t sts
);
	// remainder kept below 2*den, so 33 bits
	logic [kvs_pkg::DATA_W:0] rem_q;
	logic [kvs_pkg::DATA_W-1:0] den_q;
	logic [kvs_pkg::WGT_W-1:0] quo_q;
	logic [4:0] cnt_q;
	logic busy_q, done_q;
	logic [kvs_pkg::DATA_W+1:0] shl;
	logic ge;

	assign shl = {rem_q, 1'b0};
	assign ge  = shl >= {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(kvs_pkg::DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			// first quotient bit: num >= den (num <= den, so bit 16)
			den_q <= cmd.den;
			if (cmd.num >= cmd.den) begin
				rem_q <= {1'b0, cmd.num - cmd.den};
				quo_q <= {{(kvs_pkg::WGT_W-1){1'b0}}, 1'b1};
			end else begin
				rem_q <= {1'b0, cmd.num};
				quo_q <= '0;
			end
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= (kvs_pkg::DATA_W+1)'(shl - {2'b00, den_q});
			end else begin
				rem_q <= shl[kvs_pkg::DATA_W:0];
			end
			quo_q <= {quo_q[kvs_pkg::WGT_W-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign sts.quo  = quo_q;
endmodule

// ===== rtl/keyframe_vector_sampler.sv =====
// A load is written into the key table when it is accepted. A sample scans segments through
// RD0, RD1 and CHK, then runs the divider and MUL/ADD per component; at or before key 0,
// past the last key or on a zero-length segment it emits a key; an empty table gives zero.
// Throughput: one transaction in flight; in_ready stays low until the result is taken.
// The serial divider and the key scan set the cost. Reset: arst_n clears
// control and key_count; key tables are not cleared and hold garbage until loaded.
// ----------------------------------------------------------------------------
// keyframe_vector_sampler: keyframe table with linear vector interpolation
// Sequencer scans segments, runs a shared divider and one shared multiplier.
// ----------------------------------------------------------------------------
module keyframe_vector_sampler (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_ready,
	input  logic mode,
	input  logic [3:0] key_index,
	input  logic [31:0] time_value,
	input  logic signed [31:0] in_x,
	input  logic signed [31:0] in_y,
	input  logic signed [31:0] in_z,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z
);
	localparam int DW = kvs_pkg::DATA_W;
	localparam int IW = kvs_pkg::IDX_W;
	localparam int CW = kvs_pkg::CNT_W;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD0  = 4'd1;  // read entry i
	localparam logic [3:0] ST_RD1  = 4'd2;  // read entry i+1
	localparam logic [3:0] ST_CHK  = 4'd3;  // compare bracket
	localparam logic [3:0] ST_DIV  = 4'd4;
	localparam logic [3:0] ST_MUL  = 4'd5;  // multiply one component; ST_ADD then adds it
	localparam logic [3:0] ST_ADD  = 4'd6;
	localparam logic [3:0] ST_KEY  = 4'd7;  // emit key at rd index
	localparam logic [3:0] ST_KEY1 = 4'd8;
	localparam logic [3:0] ST_OUT  = 4'd9;

	// configuration register
	logic [CW-1:0] key_count_q;
	logic [4:0] cnt_raw_q;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_raw_q <= '0;
		end else if (psel && penable && pwrite && paddr[1:0] == {kvs_pkg::REG_KEY_COUNT, 1'b0}) begin
			cnt_raw_q <= pwdata[4:0];
		end
	end
	assign prdata = (paddr == {kvs_pkg::REG_KEY_COUNT, 1'b0}) ? {27'd0, cnt_raw_q} : 32'd0;
	// clamp to table depth
	assign key_count_q = (cnt_raw_q > 5'(kvs_pkg::MAX_KEYS)) ?
		CW'(kvs_pkg::MAX_KEYS) : CW'(cnt_raw_q);

	// key table memory: one write port, one registered read port
	logic [4*DW-1:0] mem [kvs_pkg::MAX_KEYS];
	logic [4*DW-1:0] rd_data;
	logic [IW-1:0] rd_addr;
	logic wr_en;
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[key_index] <= {time_value, in_x, in_y, in_z};
		end
		rd_data <= mem[rd_addr];
	end

	logic [3:0] state_q;
	logic [IW-1:0] idx_q;
	logic [DW-1:0] tv_q, t0_q;
	logic [DW-1:0] ax_q, ay_q, az_q;
	logic signed [DW:0] dx_q, dy_q, dz_q;
	logic [1:0] comp_q;
	logic signed [DW-1:0] rx_q, ry_q, rz_q;
	logic signed [DW+kvs_pkg::WGT_W+1:0] prod_s1;
	logic out_valid_q;
	logic div_start_q;
	logic [DW-1:0] div_num_q, div_den_q;

	kvs_pkg::div_cmd_t div_cmd;
	kvs_pkg::div_sts_t div_sts;
	assign div_cmd.start = div_start_q;
	assign div_cmd.num   = div_num_q;
	assign div_cmd.den   = div_den_q;
	kvs_div u_div (.clk(clk), .arst_n(arst_n), .cmd(div_cmd), .sts(div_sts));

	wire in_fire = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign wr_en = in_fire && mode == kvs_pkg::MODE_LOAD;

	logic [DW-1:0] rt;
	assign rt = rd_data[4*DW-1:3*DW];

	// shared multiplier operand select
	logic signed [DW:0] mul_a;
	always_comb begin
		case (comp_q)
			2'd0:    mul_a = dx_q;
			2'd1:    mul_a = dy_q;
			default: mul_a = dz_q;
		endcase
	end

	logic last_seg;
	assign last_seg = ({1'b0, idx_q} + CW'(2)) >= key_count_q;

	// RD0 fetches entry i, RD1 fetches entry i+1; the data lands in the following cycle
	always_comb begin
		rd_addr = idx_q;
		if (state_q == ST_RD1) rd_addr = IW'(idx_q + IW'(1));
		if (state_q == ST_IDLE) rd_addr = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_fire && mode == kvs_pkg::MODE_SAMPLE) begin
					if (key_count_q == '0) state_q <= ST_OUT;
					else state_q <= ST_RD0;
				end
				ST_RD0: state_q <= ST_RD1;
				ST_RD1: begin
					// rd_data holds entry i
					if (idx_q == '0 && (key_count_q == CW'(1) || tv_q <= rt))
						state_q <= ST_KEY1;
					else state_q <= ST_CHK;
				end
				ST_CHK: begin
					// rd_data holds entry i+1
					if (t0_q <= tv_q && tv_q <= rt) begin
						if (rt == t0_q) state_q <= ST_KEY;
						else begin
							div_start_q <= 1'b1;
							state_q <= ST_DIV;
						end
					end else if (last_seg) state_q <= ST_KEY1;
					else state_q <= ST_RD0;
				end
				ST_DIV: if (div_sts.done) state_q <= ST_MUL;
				ST_MUL: state_q <= ST_ADD;
				ST_ADD: state_q <= (comp_q == 2'd2) ? ST_OUT : ST_MUL;
				ST_KEY: state_q <= ST_KEY1;
				ST_KEY1: state_q <= ST_OUT;
				ST_OUT: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_fire) begin
				tv_q <= time_value;
				idx_q <= '0;
				rx_q <= '0; ry_q <= '0; rz_q <= '0;
			end
			ST_RD1: begin
				t0_q <= rt;
				ax_q <= rd_data[3*DW-1:2*DW];
				ay_q <= rd_data[2*DW-1:DW];
				az_q <= rd_data[DW-1:0];
			end
			ST_CHK: begin
				dx_q <= $signed({rd_data[3*DW-1], rd_data[3*DW-1:2*DW]}) -
					$signed({ax_q[DW-1], ax_q});
				dy_q <= $signed({rd_data[2*DW-1], rd_data[2*DW-1:DW]}) -
					$signed({ay_q[DW-1], ay_q});
				dz_q <= $signed({rd_data[DW-1], rd_data[DW-1:0]}) -
					$signed({az_q[DW-1], az_q});
				div_num_q <= tv_q - t0_q;
				div_den_q <= rt - t0_q;
				comp_q <= 2'd0;
				// no bracket: on the last segment the last key is entry i+1, which rd_data holds now; else step on
				if (!(t0_q <= tv_q && tv_q <= rt)) begin
					if (last_seg) begin
						ax_q <= rd_data[3*DW-1:2*DW];
						ay_q <= rd_data[2*DW-1:DW];
						az_q <= rd_data[DW-1:0];
					end else idx_q <= IW'(idx_q + IW'(1));
				end
			end
			ST_MUL: prod_s1 <= mul_a * $signed({1'b0, div_sts.quo});
			ST_ADD: begin
				case (comp_q)
					2'd0: rx_q <= $signed(ax_q) + DW'(prod_s1 >>> 16);
					2'd1: ry_q <= $signed(ay_q) + DW'(prod_s1 >>> 16);
					default: rz_q <= $signed(az_q) + DW'(prod_s1 >>> 16);
				endcase
				comp_q <= comp_q + 2'd1;
			end
			ST_KEY1: begin
				rx_q <= ax_q; ry_q <= ay_q; rz_q <= az_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_x = rx_q;
	assign out_y = ry_q;
	assign out_z = rz_q;

`ifndef SYNTHESIS
	a_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready) else $error("ready while busy");
	a_div_once: assert property (@(posedge clk) disable iff (!arst_n)
		div_cmd.start |=> (state_q == ST_DIV)) else $error("divider start off state");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(out_x) && out_valid)
		else $error("result changed while stalled");
`endif
endmodule

// ===== sim/tb_keyframe_vector_sampler.sv =====
// ----------------------------------------------------------------------------
// tb_keyframe_vector_sampler: self-checking bench for the keyframe sampler
// A directed table covers the corner cases, then phases of random loads and
// samples run at several key counts. Each sample result is compared with the
// expected value in its row or with a local fixed-point interpolator.
// ----------------------------------------------------------------------------
module tb_keyframe_vector_sampler;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] ADDR_KEY_COUNT = 2'(4 * kvs_pkg::REG_KEY_COUNT);
	localparam int IDLE_LIMIT   = 5000;  // cycles with no transaction at all
	localparam int DRAIN_CYCLES = 80;    // worst-case sample latency, rounded up
	localparam int ERR_SHOW     = 10;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} vec_t;

	// one row of the directed table
	typedef struct {
		bit          cfg_en;   // rewrite key_count (after draining) before this row
		logic [4:0]  cfg_val;
		logic        mode;
		logic [3:0]  idx;
		logic [31:0] tv;
		vec_t        v;
		bit          typed;    // expected result given in the row itself
		vec_t        res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0, in_ready;
	logic mode = kvs_pkg::MODE_LOAD;
	logic [3:0] key_index = '0;
	logic [31:0] time_value = '0;
	logic signed [31:0] in_x = '0, in_y = '0, in_z = '0;
	logic out_valid, out_ready = 1'b0;
	logic signed [31:0] out_x, out_y, out_z;

	keyframe_vector_sampler dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 0;
	end

	// bench copy of the block state
	logic [31:0] key_t_mirror [kvs_pkg::MAX_KEYS];
	vec_t        key_v_mirror [kvs_pkg::MAX_KEYS];
	logic [4:0]  key_count_mirror = '0;

	vec_t sample_q [$];   // expected sample vectors, oldest first
	row_t rows [$];
	int   err_cnt = 0;
	int   idle_cycles = 0;
	int   burst_left = 0;

	// component lerp: a + floor((b - a) * w / 2^16), 64-bit signed product
	function automatic logic [31:0] lerp_q16(logic [31:0] a, logic [31:0] b,
			longint unsigned w);
		longint sa, diff, prod, r;
		sa   = longint'($signed(a));
		diff = longint'($signed(b)) - sa;
		prod = diff * longint'(w);
		r    = sa + (prod >>> 16);
		return r[31:0];
	endfunction

	function automatic vec_t interp_at(logic [31:0] tv);
		int n;
		logic [31:0] t0, t1, dt;
		longint unsigned w, num, den;
		vec_t r;
		n = (key_count_mirror > kvs_pkg::MAX_KEYS) ? kvs_pkg::MAX_KEYS :
			int'(key_count_mirror);
		if (n == 0)
			return '0;
		if (n == 1 || tv <= key_t_mirror[0])
			return key_v_mirror[0];
		for (int i = 0; i + 1 < n; i++) begin
			t0 = key_t_mirror[i];
			t1 = key_t_mirror[i+1];
			if (t0 <= tv && tv <= t1) begin
				dt = t1 - t0;
				// zero-length segment holds its start key
				if (dt == 0)
					return key_v_mirror[i];
				num = tv - t0;
				den = dt;
				w = (num << 16) / den;
				r.x = lerp_q16(key_v_mirror[i].x, key_v_mirror[i+1].x, w);
				r.y = lerp_q16(key_v_mirror[i].y, key_v_mirror[i+1].y, w);
				r.z = lerp_q16(key_v_mirror[i].z, key_v_mirror[i+1].z, w);
				return r;
			end
		end
		return key_v_mirror[n-1];  // past every bracketing segment
	endfunction

	// APB write: setup cycle, then access cycle; pready is always high
	task automatic apb_write(logic [1:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (addr == ADDR_KEY_COUNT)
			key_count_mirror = data[4:0];
	endtask

	// wait for every result, then run on for the drain margin
	task automatic drain();
		while (sample_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_key_count(logic [4:0] cnt);
		in_valid <= 1'b0;
		drain();
		apb_write(ADDR_KEY_COUNT, {27'b0, cnt});
	endtask

	// Drive one transaction. Bursts of random length are separated by idle gaps, some of zero length.
	// in_ready is read right after the edge, so it is the pre-edge value.
	task automatic send(logic m, logic [3:0] idx, logic [31:0] tv, vec_t v,
			bit typed, vec_t res);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		mode <= m; key_index <= idx; time_value <= tv;
		in_x <= v.x; in_y <= v.y; in_z <= v.z;
		do @(posedge clk); while (!in_ready);
		// transaction accepted at this edge
		if (m == kvs_pkg::MODE_LOAD) begin
			key_t_mirror[idx] = tv;
			key_v_mirror[idx] = v;
		end else begin
			sample_q.insert(sample_q.size(), typed ? res : interp_at(tv));
		end
	endtask

	task automatic send_row(row_t r);
		if (r.cfg_en)
			set_key_count(r.cfg_val);
		send(r.mode, r.idx, r.tv, r.v, r.typed, r.res);
	endtask

	function automatic void add_row(bit ce, logic [4:0] cv, logic m, logic [3:0] idx,
			logic [31:0] tv, vec_t v, bit typed, vec_t res);
		row_t r;
		r.cfg_en = ce; r.cfg_val = cv; r.mode = m; r.idx = idx; r.tv = tv;
		r.v = v; r.typed = typed; r.res = res;
		rows.insert(rows.size(), r);
	endfunction

	function automatic vec_t rand_vec();
		vec_t v;
		v.x = $urandom; v.y = $urandom; v.z = $urandom;
		return v;
	endfunction

	// key times on a rising grid, with some fully random ones to break order
	function automatic logic [31:0] rand_key_time(logic [3:0] idx);
		if ($urandom_range(0, 9) < 2)
			return $urandom;
		return {8'b0, idx, 20'b0} + $urandom_range(0, 32'hF_FFFF);
	endfunction

	function automatic logic [31:0] rand_sample_time();
		case ($urandom_range(0, 9))
			0:       return $urandom;
			1:       return key_t_mirror[$urandom_range(0, kvs_pkg::MAX_KEYS-1)];
			2:       return 32'h0;
			default: return $urandom_range(0, 32'h0110_0000);
		endcase
	endfunction

	// Result side: stall pattern, checking and idle watchdog.
	// All reads here see the values from before the edge.
	int stall_mode = 0;
	int stall_left = 0;
	always @(posedge clk) begin
		vec_t want, got;
		if (arst_n && ((in_valid && in_ready) || (out_valid && out_ready)))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
		if (out_valid && out_ready) begin
			got = {out_x, out_y, out_z};
			if (sample_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= ERR_SHOW)
					$display("unexpected result %h %h %h", out_x, out_y, out_z);
			end else begin
				want = sample_q.pop_front();
				if (got !== want) begin
					err_cnt++;
					if (err_cnt <= ERR_SHOW)
						$display("mismatch: exp %h %h %h got %h %h %h",
							want.x, want.y, want.z, got.x, got.y, got.z);
				end
			end
		end
		// receiver: stretches always ready, light stalls, or heavy stalls
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(20, 200);
		end
		stall_left--;
		case (stall_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	initial begin
		vec_t k0, k1, k2, k3, nil, v;
		logic [4:0] counts [$];
		int nitems;
		logic [3:0] idx;

		nil = '0;
		k0 = {32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000};
		k1 = {32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000};
		k2 = {32'h0000_0001, 32'hFFFF_FFFF, 32'h1234_5678};
		k3 = {32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF};

		// empty table gives zero
		add_row(1, 5'd0, kvs_pkg::MODE_SAMPLE, 4'd0, 32'h0, nil, 1, nil);
		add_row(0, 5'd0, kvs_pkg::MODE_SAMPLE, 4'd15, 32'hFFFF_FFFF, k0, 1, nil);
		// keys 0..3 and 15, with a repeated time at keys 1 and 2
		add_row(0, 5'd0, kvs_pkg::MODE_LOAD, 4'd0, 32'h0001_0000, k0, 0, nil);
		add_row(0, 5'd0, kvs_pkg::MODE_LOAD, 4'd1, 32'h0002_0000, k1, 0, nil);
		add_row(0, 5'd0, kvs_pkg::MODE_LOAD, 4'd2, 32'h0002_0000, k2, 0, nil);
		add_row(0, 5'd0, kvs_pkg::MODE_LOAD, 4'd3, 32'h0003_0000, k3, 0, nil);
		add_row(0, 5'd0, kvs_pkg::MODE_LOAD, 4'd15, 32'hFFFF_FFFF, k1, 0, nil);
		// single key always gives key 0
		add_row(1, 5'd1, kvs_pkg::MODE_SAMPLE, 4'd0, 32'h0002_8000, nil, 1, k0);
		// time at or before key 0
		add_row(1, 5'd4, kvs_pkg::MODE_SAMPLE, 4'd0, 32'h0, nil, 1, k0);
		add_row(0, 5'd0, kvs_pkg::MODE_SAMPLE, 4'd0, 32'h0001_0000, nil, 1, k0);
		// interior points, full-scale differences
		add_row(0, 5'd0, kvs_pkg::MODE_SAMPLE, 4'd0, 32'h0001_8000, nil, 0, nil);
		add_row(0, 5'd0, kvs_pkg::MODE_SAMPLE, 4'd0, 32'h0002_0000, nil, 0, nil);
		add_row(0, 5'd0, kvs_pkg::MODE_SAMPLE, 4'd0, 32'h0002_8000, nil, 0, nil);
		add_row(0, 5'd0, kvs_pkg::MODE_SAMPLE, 4'd0, 32'h0003_0000, nil, 0, nil);
		add_row(0, 5'd0, kvs_pkg::MODE_SAMPLE, 4'd9, 32'h0001_FFFF, k2, 0, nil);
		// beyond the last key
		add_row(0, 5'd0, kvs_pkg::MODE_SAMPLE, 4'd0, 32'hFFFF_FFFF, nil, 1, k3);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_row(rows[i]);

		// fill the whole table before any wider key count is used
		for (int i = 0; i < kvs_pkg::MAX_KEYS; i++)
			send(kvs_pkg::MODE_LOAD, 4'(i), rand_key_time(4'(i)), rand_vec(), 0, nil);

		// key counts per phase: extremes, over-range values and random ones
		counts = '{5'd16, 5'd0, 5'd1, 5'd2, 5'd31, 5'd17, 5'd3, 5'd8};
		repeat (6) counts.insert(counts.size(), 5'($urandom_range(2, 16)));

		foreach (counts[p]) begin
			set_key_count(counts[p]);
			nitems = 40;
			for (int j = 0; j < nitems; j++) begin
				if ($urandom_range(0, 3) == 0) begin
					idx = 4'($urandom_range(0, kvs_pkg::MAX_KEYS-1));
					v = rand_vec();
					send(kvs_pkg::MODE_LOAD, idx, rand_key_time(idx), v, 0, nil);
				end else begin
					send(kvs_pkg::MODE_SAMPLE, 4'($urandom), rand_sample_time(),
						rand_vec(), 0, nil);
				end
			end
		end

		in_valid <= 1'b0;
		drain();
		if (err_cnt == 0 && sample_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/kvs_pkg.sv
rtl/kvs_div.sv
rtl/keyframe_vector_sampler.sv
sim/tb_keyframe_vector_sampler.sv
